FILE: hw/rtl/mcfp_pkg.sv
// ----------------------------------------------------------------------------
// MQTT CONNECT field parser package
// Shared types, field codes and helper functions for the CONNECT byte tagger.
// ----------------------------------------------------------------------------
package mcfp_pkg;

  // Field codes, also used as the parser phase.
  typedef enum logic [4:0] {
    FC_TYPE      = 5'd0,
    FC_REMLEN    = 5'd1,
    FC_NAME_LEN  = 5'd2,
    FC_NAME_CHR  = 5'd3,
    FC_LEVEL     = 5'd4,
    FC_FLAGS     = 5'd5,
    FC_KEEPALIVE = 5'd6,
    FC_CID_LEN   = 5'd7,
    FC_CID_CHR   = 5'd8,
    FC_WTOP_LEN  = 5'd9,
    FC_WTOP_CHR  = 5'd10,
    FC_WMSG_LEN  = 5'd11,
    FC_WMSG_CHR  = 5'd12,
    FC_USER_LEN  = 5'd13,
    FC_USER_CHR  = 5'd14,
    FC_PASS_LEN  = 5'd15,
    FC_PASS_CHR  = 5'd16,
    FC_EXTRA     = 5'd17
  } field_code_t;

  // Bit positions inside the connect flags byte.
  localparam int FLAG_WILL_BIT = 2;
  localparam int FLAG_PASS_BIT = 6;
  localparam int FLAG_USER_BIT = 7;

  // Packets that end before this many bytes are flagged as short.
  localparam logic [8:0]  MIN_PACKET   = 9'd3;
  localparam logic [8:0]  CONSUMED_MAX = 9'd511;
  localparam logic [15:0] POSITION_MAX = 16'hffff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_packet;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  field_code;
    logic [7:0]  byte_value;
    logic [15:0] byte_index;
    logic [3:0]  packet_type;
    logic [7:0]  connect_flags;
    logic [15:0] keep_alive;
    logic        packet_done;
    logic        status;
  } out_item_t;

  // Character field that follows a length field.
  function automatic field_code_t chr_of_len(field_code_t code);
    field_code_t nxt;
    nxt = FC_EXTRA;
    case (code)
      FC_NAME_LEN: nxt = FC_NAME_CHR;
      FC_CID_LEN:  nxt = FC_CID_CHR;
      FC_WTOP_LEN: nxt = FC_WTOP_CHR;
      FC_WMSG_LEN: nxt = FC_WMSG_CHR;
      FC_USER_LEN: nxt = FC_USER_CHR;
      FC_PASS_LEN: nxt = FC_PASS_CHR;
      default:     nxt = FC_EXTRA;
    endcase
    return nxt;
  endfunction

  // Field that follows a finished character field, given the connect flags.
  function automatic field_code_t after_field(field_code_t code, logic [7:0] flags);
    field_code_t tail;
    field_code_t nxt;
    tail = flags[FLAG_USER_BIT] ? FC_USER_LEN :
           (flags[FLAG_PASS_BIT] ? FC_PASS_LEN : FC_EXTRA);
    nxt  = FC_EXTRA;
    case (code)
      FC_NAME_CHR: nxt = FC_LEVEL;
      FC_CID_CHR:  nxt = flags[FLAG_WILL_BIT] ? FC_WTOP_LEN : tail;
      FC_WTOP_CHR: nxt = FC_WMSG_LEN;
      FC_WMSG_CHR: nxt = tail;
      FC_USER_CHR: nxt = flags[FLAG_PASS_BIT] ? FC_PASS_LEN : FC_EXTRA;
      default:     nxt = FC_EXTRA;
    endcase
    return nxt;
  endfunction

endpackage

FILE: hw/rtl/mcfp_tagger.sv
// ----------------------------------------------------------------------------
// MQTT CONNECT field tagger
// Holds the parse state and tags one byte per transaction with its field.
// ----------------------------------------------------------------------------
module mcfp_tagger (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  mcfp_pkg::in_item_t  item,
  output mcfp_pkg::out_item_t result
);

  mcfp_pkg::field_code_t phase_r, phase_nxt;
  logic        fresh_r, fresh_nxt;
  logic [15:0] field_rem_r, field_rem_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [7:0]  decl_len_r, decl_len_nxt;
  logic [8:0]  consumed_r, consumed_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] keep_alive_r, keep_alive_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [15:0] field_pos_r, field_pos_nxt;

  mcfp_pkg::field_code_t ph;
  mcfp_pkg::field_code_t code;
  logic        new_pkt;
  logic [15:0] rem;
  logic [15:0] rem_dec;
  logic [15:0] pos;
  logic [8:0]  cons;
  logic        done;

  always_comb begin
    new_pkt = item.start_of_packet || fresh_r;
    // A new packet starts from a cleared context.
    ph   = new_pkt ? mcfp_pkg::FC_TYPE : phase_r;
    rem  = new_pkt ? 16'd0 : field_rem_r;
    pos  = new_pkt ? 16'd0 : field_pos_r;
    cons = new_pkt ? 9'd0 : consumed_r;

    len_hi_nxt     = new_pkt ? 8'd0 : len_hi_r;
    decl_len_nxt   = new_pkt ? 8'd0 : decl_len_r;
    flags_nxt      = new_pkt ? 8'd0 : flags_r;
    keep_alive_nxt = new_pkt ? 16'd0 : keep_alive_r;
    type_nxt       = type_r;
    field_rem_nxt  = rem;
    field_pos_nxt  = pos;
    phase_nxt      = ph;
    code           = ph;
    consumed_nxt   = (cons < mcfp_pkg::CONSUMED_MAX) ? cons + 9'd1 : cons;
    rem_dec        = (rem != 16'd0) ? rem - 16'd1 : rem;

    case (ph)
      mcfp_pkg::FC_TYPE: begin
        type_nxt      = item.data_byte[7:4];
        phase_nxt     = mcfp_pkg::FC_REMLEN;
        field_pos_nxt = 16'd0;
      end
      mcfp_pkg::FC_REMLEN: begin
        decl_len_nxt  = item.data_byte;
        phase_nxt     = mcfp_pkg::FC_NAME_LEN;
        field_pos_nxt = 16'd0;
      end
      mcfp_pkg::FC_LEVEL: begin
        phase_nxt     = mcfp_pkg::FC_FLAGS;
        field_pos_nxt = 16'd0;
      end
      mcfp_pkg::FC_FLAGS: begin
        flags_nxt     = item.data_byte;
        phase_nxt     = mcfp_pkg::FC_KEEPALIVE;
        field_pos_nxt = 16'd0;
      end
      mcfp_pkg::FC_KEEPALIVE: begin
        if (pos == 16'd0) begin
          len_hi_nxt    = item.data_byte;
          field_pos_nxt = 16'd1;
        end else begin
          keep_alive_nxt = {len_hi_nxt, item.data_byte};
          phase_nxt      = mcfp_pkg::FC_CID_LEN;
          field_pos_nxt  = 16'd0;
        end
      end
      mcfp_pkg::FC_NAME_LEN, mcfp_pkg::FC_CID_LEN, mcfp_pkg::FC_WTOP_LEN,
      mcfp_pkg::FC_WMSG_LEN, mcfp_pkg::FC_USER_LEN, mcfp_pkg::FC_PASS_LEN: begin
        if (pos == 16'd0) begin
          len_hi_nxt    = item.data_byte;
          field_pos_nxt = 16'd1;
        end else begin
          field_rem_nxt = {len_hi_nxt, item.data_byte};
          field_pos_nxt = 16'd0;
          // An empty string skips its character field entirely.
          if (field_rem_nxt == 16'd0) begin
            phase_nxt = mcfp_pkg::after_field(mcfp_pkg::chr_of_len(ph), flags_nxt);
          end else begin
            phase_nxt = mcfp_pkg::chr_of_len(ph);
          end
        end
      end
      mcfp_pkg::FC_NAME_CHR, mcfp_pkg::FC_CID_CHR, mcfp_pkg::FC_WTOP_CHR,
      mcfp_pkg::FC_WMSG_CHR, mcfp_pkg::FC_USER_CHR, mcfp_pkg::FC_PASS_CHR: begin
        field_rem_nxt = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_nxt     = mcfp_pkg::after_field(ph, flags_nxt);
          field_pos_nxt = 16'd0;
        end else begin
          field_pos_nxt = pos + 16'd1;
        end
      end
      default: begin
        phase_nxt     = mcfp_pkg::FC_EXTRA;
        code          = mcfp_pkg::FC_EXTRA;
        field_pos_nxt = (pos < mcfp_pkg::POSITION_MAX) ? pos + 16'd1 : pos;
      end
    endcase

    done = (consumed_nxt == ({1'b0, decl_len_nxt} + 9'd2)) && (code != mcfp_pkg::FC_TYPE);
    if (done) begin
      phase_nxt     = mcfp_pkg::FC_EXTRA;
      field_pos_nxt = 16'd0;
    end
    fresh_nxt = item.end_of_input ? 1'b1 : 1'b0;

    result.field_code    = code;
    result.byte_value    = item.data_byte;
    result.byte_index    = pos;
    result.packet_type   = type_nxt;
    result.connect_flags = flags_nxt;
    result.keep_alive    = keep_alive_nxt;
    result.packet_done   = done;
    result.status        = item.end_of_input && (consumed_nxt < mcfp_pkg::MIN_PACKET);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mcfp_pkg::FC_TYPE;
      fresh_r      <= 1'b1;
      field_rem_r  <= 16'd0;
      len_hi_r     <= 8'd0;
      decl_len_r   <= 8'd0;
      consumed_r   <= 9'd0;
      flags_r      <= 8'd0;
      keep_alive_r <= 16'd0;
      type_r       <= 4'd0;
      field_pos_r  <= 16'd0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      fresh_r      <= fresh_nxt;
      field_rem_r  <= field_rem_nxt;
      len_hi_r     <= len_hi_nxt;
      decl_len_r   <= decl_len_nxt;
      consumed_r   <= consumed_nxt;
      flags_r      <= flags_nxt;
      keep_alive_r <= keep_alive_nxt;
      type_r       <= type_nxt;
      field_pos_r  <= field_pos_nxt;
    end
  end

  // Once the declared length is reached, only extra bytes follow.
  a_done_to_extra: assert property (@(posedge clk) disable iff (!rst_n)
    advance && result.packet_done |=> phase_r == mcfp_pkg::FC_EXTRA)
    else $error("packet_done did not move the parser to the extra phase");

  // A short packet always ends the buffer, so the next byte starts anew.
  a_short_then_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    advance && result.status |=> fresh_r)
    else $error("short packet status without a following restart");

  // The first byte of a packet is always the type byte.
  a_sop_is_type: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.start_of_packet |-> result.field_code == mcfp_pkg::FC_TYPE)
    else $error("start of packet not tagged as type byte");

  // A character field is only entered with characters left to take.
  a_chr_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == mcfp_pkg::FC_NAME_CHR || phase_r == mcfp_pkg::FC_CID_CHR ||
     phase_r == mcfp_pkg::FC_WTOP_CHR || phase_r == mcfp_pkg::FC_WMSG_CHR ||
     phase_r == mcfp_pkg::FC_USER_CHR || phase_r == mcfp_pkg::FC_PASS_CHR)
    |-> field_rem_r != 16'd0)
    else $error("character phase with no characters remaining");

endmodule

FILE: hw/rtl/mcfp_out_reg.sv
// ----------------------------------------------------------------------------
// MQTT CONNECT field parser output register
// Holds one tagged result until the receiver takes it.
// ----------------------------------------------------------------------------
module mcfp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  mcfp_pkg::out_item_t load_data,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output mcfp_pkg::out_item_t out_data
);

  logic                valid_r;
  mcfp_pkg::out_item_t data_r;

  // The register can take a new result when empty or when it drains now.
  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

FILE: hw/rtl/mqtt_connect_field_parser.sv
// ----------------------------------------------------------------------------
// MQTT CONNECT field parser
// Tags each byte of a CONNECT packet with the field that it belongs to.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_data) carries one packet byte per
// transaction together with start-of-packet and end-of-buffer marks. For each
// input transaction the block returns exactly one result transaction on the
// output channel (out_valid, out_ready, out_data) naming the field, the byte
// position inside it, and the latched type, connect flags and keep-alive.
// A result appears on the output the cycle after its byte is accepted, at
// one byte per cycle while the receiver takes each result; the per-byte
// work is a small state update that fits between the parse state and the
// output register. When the receiver stalls, the output register holds its
// result and in_ready follows out_ready, so a new byte is taken in the same
// cycle the waiting result leaves. After reset the output is empty and the
// first byte accepted is treated as the type byte of a new packet.
// ----------------------------------------------------------------------------
module mqtt_connect_field_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcfp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcfp_pkg::out_item_t out_data
);

  logic                accept;
  mcfp_pkg::out_item_t tag_data;

  // A transaction is taken whenever the output register has room for it.
  assign accept = in_valid && in_ready;

  // Parse state and per-byte tagging logic.
  mcfp_tagger u_tagger (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(accept),
    .item   (in_data),
    .result (tag_data)
  );

  // Result register that decouples the receiver from the parser.
  mcfp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .load_data(tag_data),
    .space    (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

FILE: bench/mqtt_connect_field_parser_tb.sv
// ----------------------------------------------------------------------------
// MQTT CONNECT field parser testbench
// Streams CONNECT packets, short packets and raw byte noise into the parser
// under random sender gaps and receiver stalls. A byte-level tagger inside
// the bench predicts the field tag of every byte, and each result
// transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mqtt_connect_field_parser_tb;

  // Size of the random part, counted in input bytes.
  localparam int RANDOM_BYTES = 200;
  // Bytes sent after the declared length in the long stream. This is enough
  // to carry the packet byte counter past its ceiling.
  localparam int LONG_TAIL    = 520;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  mcfp_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mcfp_pkg::out_item_t out_data;

  mqtt_connect_field_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Byte tagger: the bench's own copy of the parse state. It is advanced once
  // per accepted input transaction, in the same order as the block sees them.
  // --------------------------------------------------------------------------
  mcfp_pkg::field_code_t p_phase;
  logic [15:0] p_left;      // characters still owed by the current string
  logic [15:0] p_pos;       // position inside the current field
  logic [15:0] p_keep;
  logic [7:0]  p_hi;        // high byte of a big-endian pair
  logic [7:0]  p_declared;  // remaining length byte
  logic [7:0]  p_flags;
  logic [8:0]  p_count;     // bytes of this packet so far, saturating
  logic [3:0]  p_type;
  logic        p_fresh;     // next byte opens a packet even without a mark

  // Predicted tags that still wait for their result transaction.
  mcfp_pkg::out_item_t pending_tags[$];

  // Bytes of the packet being assembled by the stimulus.
  logic [7:0] pkt[$];

  int  bytes_sent;
  int  packets_sent;
  int  tags_checked;
  int  mismatches;
  int  burst_left;
  bit  steady;      // no sender gaps while set
  bit  last_eoi;

  function automatic void reset_tagger();
    p_phase    = mcfp_pkg::FC_TYPE;
    p_left     = '0;
    p_pos      = '0;
    p_keep     = '0;
    p_hi       = '0;
    p_declared = '0;
    p_flags    = '0;
    p_count    = '0;
    p_type     = '0;
    p_fresh    = 1'b1;
  endfunction

  function automatic void move_to(mcfp_pkg::field_code_t nxt);
    p_phase = nxt;
    p_pos   = '0;
  endfunction

  // Field that comes after a finished string. The will pair, username and
  // password are each present only when their flag bit is set.
  function automatic mcfp_pkg::field_code_t field_after(mcfp_pkg::field_code_t finished);
    mcfp_pkg::field_code_t tail;
    if (p_flags[mcfp_pkg::FLAG_USER_BIT]) tail = mcfp_pkg::FC_USER_LEN;
    else if (p_flags[mcfp_pkg::FLAG_PASS_BIT]) tail = mcfp_pkg::FC_PASS_LEN;
    else tail = mcfp_pkg::FC_EXTRA;
    case (finished)
      mcfp_pkg::FC_NAME_CHR: return mcfp_pkg::FC_LEVEL;
      mcfp_pkg::FC_CID_CHR:
        return p_flags[mcfp_pkg::FLAG_WILL_BIT] ? mcfp_pkg::FC_WTOP_LEN : tail;
      mcfp_pkg::FC_WTOP_CHR: return mcfp_pkg::FC_WMSG_LEN;
      mcfp_pkg::FC_WMSG_CHR: return tail;
      mcfp_pkg::FC_USER_CHR:
        return p_flags[mcfp_pkg::FLAG_PASS_BIT] ? mcfp_pkg::FC_PASS_LEN : mcfp_pkg::FC_EXTRA;
      default:               return mcfp_pkg::FC_EXTRA;
    endcase
  endfunction

  function automatic mcfp_pkg::out_item_t tag_byte(mcfp_pkg::in_item_t it);
    mcfp_pkg::out_item_t   r;
    mcfp_pkg::field_code_t code;
    logic [15:0] idx;
    logic [7:0]  b;
    logic        done;
    b = it.data_byte;
    // A start mark, the first byte after reset and the first byte after an
    // end-of-buffer byte all open a new packet with cleared latches.
    if (it.start_of_packet || p_fresh) begin
      p_phase    = mcfp_pkg::FC_TYPE;
      p_left     = '0;
      p_hi       = '0;
      p_declared = '0;
      p_count    = '0;
      p_flags    = '0;
      p_keep     = '0;
      p_pos      = '0;
      p_fresh    = 1'b0;
    end
    code = p_phase;
    idx  = p_pos;
    if (p_count != mcfp_pkg::CONSUMED_MAX) p_count = p_count + 9'd1;

    case (code)
      mcfp_pkg::FC_TYPE: begin
        p_type = b[7:4];
        move_to(mcfp_pkg::FC_REMLEN);
      end
      mcfp_pkg::FC_REMLEN: begin
        p_declared = b;
        move_to(mcfp_pkg::FC_NAME_LEN);
      end
      mcfp_pkg::FC_LEVEL: move_to(mcfp_pkg::FC_FLAGS);
      mcfp_pkg::FC_FLAGS: begin
        p_flags = b;
        move_to(mcfp_pkg::FC_KEEPALIVE);
      end
      mcfp_pkg::FC_KEEPALIVE: begin
        if (idx == 16'd0) begin
          p_hi  = b;
          p_pos = 16'd1;
        end else begin
          p_keep = {p_hi, b};
          move_to(mcfp_pkg::FC_CID_LEN);
        end
      end
      mcfp_pkg::FC_NAME_LEN, mcfp_pkg::FC_CID_LEN, mcfp_pkg::FC_WTOP_LEN,
      mcfp_pkg::FC_WMSG_LEN, mcfp_pkg::FC_USER_LEN, mcfp_pkg::FC_PASS_LEN: begin
        if (idx == 16'd0) begin
          p_hi  = b;
          p_pos = 16'd1;
        end else begin
          p_left = {p_hi, b};
          move_to(mcfp_pkg::field_code_t'(code + 5'd1));
          // An empty string has no character bytes at all.
          if (p_left == 16'd0) begin
            move_to(field_after(mcfp_pkg::field_code_t'(code + 5'd1)));
          end
        end
      end
      mcfp_pkg::FC_NAME_CHR, mcfp_pkg::FC_CID_CHR, mcfp_pkg::FC_WTOP_CHR,
      mcfp_pkg::FC_WMSG_CHR, mcfp_pkg::FC_USER_CHR, mcfp_pkg::FC_PASS_CHR: begin
        if (p_left != 16'd0) p_left = p_left - 16'd1;
        if (p_left == 16'd0) move_to(field_after(code));
        else p_pos = idx + 16'd1;
      end
      default: begin
        p_phase = mcfp_pkg::FC_EXTRA;
        code    = mcfp_pkg::FC_EXTRA;
        if (p_pos != mcfp_pkg::POSITION_MAX) p_pos = p_pos + 16'd1;
      end
    endcase

    // The byte that reaches remaining length + 2 closes the packet, in
    // whatever field it falls; everything after it is extra.
    done = (int'(p_count) == int'(p_declared) + 2) && (code != mcfp_pkg::FC_TYPE);
    if (done) move_to(mcfp_pkg::FC_EXTRA);

    r.field_code    = code;
    r.byte_value    = b;
    r.byte_index    = idx;
    r.packet_type   = p_type;
    r.connect_flags = p_flags;
    r.keep_alive    = p_keep;
    r.packet_done   = done;
    r.status        = it.end_of_input && (p_count < mcfp_pkg::MIN_PACKET);
    if (it.end_of_input) p_fresh = 1'b1;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker. A result transaction completes at an edge where out_valid
  // and out_ready are both high; the values read here are the ones from just
  // before that edge.
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    mcfp_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tags.size() == 0) begin
        $error("result transaction arrived with no byte waiting for it");
        mismatches++;
      end else begin
        want = pending_tags.pop_front();
        tags_checked++;
        check_field("field_code", 16'(want.field_code), 16'(out_data.field_code));
        check_field("byte_value", 16'(want.byte_value), 16'(out_data.byte_value));
        check_field("byte_index", want.byte_index, out_data.byte_index);
        check_field("packet_type", 16'(want.packet_type), 16'(out_data.packet_type));
        check_field("connect_flags", 16'(want.connect_flags),
                    16'(out_data.connect_flags));
        check_field("keep_alive", want.keep_alive, out_data.keep_alive);
        check_field("packet_done", 16'(want.packet_done), 16'(out_data.packet_done));
        check_field("status", 16'(want.status), 16'(out_data.status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure. Ready runs of random length alternate with short
  // stalls, and now and then a long run gives a stretch with no stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ready
    int ready_left;
    int stall_left;
    if (ready_left != 0) begin
      out_ready <= 1'b1;
      ready_left--;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready  <= 1'b1;
      ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
      stall_left = $urandom_range(1, 6);
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Bytes go out in bursts of random length separated by random gaps.
  // Valid stays high from one byte to the next inside a burst, and is lowered
  // at the start of a gap or while the bench drains. The prediction is made
  // at the edge where the input transaction completes.
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic sop, logic eoi);
    mcfp_pkg::in_item_t it;
    int                 gap;
    it.data_byte       = b;
    it.start_of_packet = sop;
    it.end_of_input    = eoi;
    if (burst_left == 0) begin
      if (steady) begin
        burst_left = 1000;
      end else begin
        gap        = $urandom_range(0, 6);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pending_tags.push_back(tag_byte(it));
    bytes_sent++;
    last_eoi = eoi;
  endtask

  task automatic send_packet(logic sop_first, logic eoi_last);
    foreach (pkt[i]) begin
      send_byte(pkt[i], sop_first && (i == 0), eoi_last && (i == pkt.size() - 1));
    end
    packets_sent++;
  endtask

  // Hold the input idle until every predicted result has been returned.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Packet assembly for the random part.
  // --------------------------------------------------------------------------
  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 5) return 16'd0;
    if (r < 18) return 16'($urandom_range(1, 10));
    // A wide length: the packet is cut off by its declared length first.
    return 16'($urandom);
  endfunction

  // Length prefix followed by at most 20 characters; a longer string is cut
  // short by the declared length or by the next packet anyway.
  function automatic void add_string(logic [15:0] len);
    pkt.push_back(len[15:8]);
    pkt.push_back(len[7:0]);
    repeat ((len > 16'd20) ? 20 : int'(len)) pkt.push_back(8'($urandom));
  endfunction

  function automatic void build_connect();
    logic [7:0]  flags;
    logic [15:0] keep;
    int          extra;
    flags = 8'($urandom);
    keep  = 16'($urandom);
    pkt.delete();
    pkt.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h10);
    pkt.push_back(8'h00);
    add_string(($urandom_range(0, 3) != 0) ? 16'd4 : pick_length());
    pkt.push_back(8'($urandom));
    pkt.push_back(flags);
    pkt.push_back(keep[15:8]);
    pkt.push_back(keep[7:0]);
    add_string(pick_length());
    if (flags[mcfp_pkg::FLAG_WILL_BIT]) begin
      add_string(pick_length());
      add_string(pick_length());
    end
    if (flags[mcfp_pkg::FLAG_USER_BIT]) add_string(pick_length());
    if (flags[mcfp_pkg::FLAG_PASS_BIT]) add_string(pick_length());
    pkt[1] = 8'(pkt.size() - 2);
    // Damage some packets: a wrong length, a tail past the declared length,
    // or a declared length that runs past the last parsed field.
    case ($urandom_range(0, 9))
      0, 1: pkt[1] = 8'($urandom);
      2, 3: repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
      4: begin
        extra = $urandom_range(1, 4);
        if (int'(pkt[1]) + extra <= 255) pkt[1] = pkt[1] + 8'(extra);
        repeat (extra) pkt.push_back(8'($urandom));
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // One-byte and two-byte buffers. The first byte after reset opens a packet
  // without a start mark; the second buffer has the widest remaining length.
  task automatic test_short_packets();
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
  endtask

  // Every flag set, all strings empty, all-ones keep-alive. The declared
  // length ends on the password length, and one byte trails it. The packet
  // opens without a start mark, right after an end-of-buffer byte.
  task automatic test_all_fields_empty();
    pkt = '{8'hFF, 8'd16, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'hA5};
    send_packet(1'b0, 1'b0);
  endtask

  // A start mark inside an unfinished protocol name abandons that packet.
  // The new one declares zero remaining length, so it closes on its second
  // byte.
  task automatic test_restart_mid_packet();
    pkt = '{8'h10, 8'h0C, 8'h00, 8'h04};
    send_packet(1'b1, 1'b0);
    pkt = '{8'h20, 8'h00, 8'h5A};
    send_packet(1'b1, 1'b1);
  endtask

  // A packet that closes on its length byte, followed by a long tail of extra
  // bytes. The packet byte counter reaches its ceiling on the way, so a
  // counter that wrapped would close the packet a second time.
  task automatic test_counter_saturation();
    steady = 1'b1;
    send_byte(8'h10, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    for (int i = 0; i < LONG_TAIL; i++) begin
      send_byte(8'($urandom), 1'b0, i == LONG_TAIL - 1);
    end
    packets_sent++;
    steady = 1'b0;
    burst_left = 0;
  endtask

  // Mostly well-formed packets with random content, plus short buffers and
  // raw noise with stray start and end marks.
  task automatic test_random_packets();
    int  sent;
    int  first;
    int  pick;
    bit  drained;
    logic sop_first;
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_BYTES) begin
      first     = bytes_sent;
      pick      = $urandom_range(0, 99);
      sop_first = !(last_eoi && $urandom_range(0, 1) == 1);
      if (pick < 75) begin
        build_connect();
        send_packet(sop_first, $urandom_range(0, 2) == 0);
      end else if (pick < 85) begin
        pkt.delete();
        repeat ($urandom_range(1, 2)) pkt.push_back(8'($urandom));
        send_packet(sop_first, 1'b1);
      end else begin
        repeat ($urandom_range(1, 24)) begin
          send_byte(8'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 19) == 0);
        end
      end
      sent += bytes_sent - first;
      // Halfway through, let the output run dry once before going on.
      if (!drained && sent >= RANDOM_BYTES / 2) begin
        drain();
        drained = 1'b1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_tagger();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_short_packets();
    test_all_fields_empty();
    test_restart_mid_packet();
    drain();
    test_counter_saturation();
    drain();
    test_random_packets();

    // Wait for the last results, and stay running after them so that any stray
    // result transaction is still caught.
    drain();
    repeat (4) @(posedge clk);

    $display("Sent %0d bytes in %0d packets and noise bursts; %0d results compared.",
             bytes_sent, packets_sent, tags_checked);
    $display("Covered short buffers, empty and truncated fields, restarts and a long tail.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit, well above the slowest legal run.
  initial begin
    #20_000_000;
    $error("run did not finish within the time limit");
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mcfp_pkg.sv
hw/rtl/mcfp_tagger.sv
hw/rtl/mcfp_out_reg.sv
hw/rtl/mqtt_connect_field_parser.sv
bench/mqtt_connect_field_parser_tb.sv
